[sv/session_handshake_arbiter_defines.svh]
// ----------------------------------------------------------------------------
// session_handshake_arbiter_defines
// assertion macros shared by the session arbiter rtl
// ----------------------------------------------------------------------------
`ifndef SESSION_HANDSHAKE_ARBITER_DEFINES_SVH
`define SESSION_HANDSHAKE_ARBITER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SHSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define SHSA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/shsa_pkg.sv]
// ----------------------------------------------------------------------------
// shsa_pkg
// types and constants of the session handshake arbiter
// ----------------------------------------------------------------------------
package shsa_pkg;

  typedef enum logic [2:0] {
    KIND_HSK_START   = 3'd0,
    KIND_SEND_NEW    = 3'd1,
    KIND_SEND_REPLY  = 3'd2,
    KIND_RX_START    = 3'd3,
    KIND_RX_ACCEPT   = 3'd4,
    KIND_RX_CONFLICT = 3'd5,
    KIND_RX_OTHER    = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_WAIT     = 2'd1,
    PH_DONE     = 2'd2,
    PH_CONFLICT = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    SK_HSK_START    = 2'd0,
    SK_HSK_ACCEPT   = 2'd1,
    SK_HSK_CONFLICT = 2'd2,
    SK_USER         = 2'd3
  } send_kind_e;

  localparam logic [1:0] CFG_OWN_BUF   = 2'd0;
  localparam logic [1:0] CFG_OWN_CKSUM = 2'd1;
  localparam logic [1:0] CFG_SEED      = 2'd2;
  localparam logic [1:0] CFG_ORIGIN    = 2'd3;

  localparam logic [15:0] HSK_LEN      = 16'd3;
  localparam logic [15:0] PEER_BUF_RST = 16'hFFFF;
  localparam logic [7:0]  CKSUM_XOR    = 8'd1;
  localparam logic [7:0]  CKSUM_CRC32  = 8'd32;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  msg_type;
    logic [15:0] session;
    logic [15:0] length;
    logic [7:0]  peer_cksum_byte;
    logic [15:0] peer_bufsize;
  } item_t;

  typedef struct packed {
    logic [14:0] counter;
    logic        origin;
    logic [15:0] pending;
    phase_e      phase;
    logic [15:0] peer_buf;
    logic [7:0]  peer_cksum;
  } state_t;

  typedef struct packed {
    logic        ok;
    logic        send;
    logic [1:0]  send_kind;
    logic [7:0]  send_type;
    logic [15:0] send_session;
    logic [7:0]  send_cksum;
    logic [15:0] send_length;
    logic        pass_to_user;
    logic        reset_framing;
    logic [1:0]  hsk_status;
  } result_t;

endpackage

[sv/shsa_decide.sv]
// ----------------------------------------------------------------------------
// shsa_decide
// per-item decision: next session state and the send result
// ----------------------------------------------------------------------------
module shsa_decide #(
  parameter bit HasCrc32 = 1'b1
) (
  input  shsa_pkg::item_t   item_i,
  input  shsa_pkg::state_t  cur_i,
  output shsa_pkg::state_t  nxt_o,
  output shsa_pkg::result_t res_o
);

  logic [15:0] limit_cur;
  logic [15:0] limit_rx;
  logic [15:0] peer_buf_rx;
  logic [15:0] sn;
  logic [14:0] counter_inc;
  logic [7:0]  peer_ck_in;
  logic        fits_len;
  logic        fits_hsk;
  logic        fits_hsk_rx;
  logic        take_peer;
  logic        match;

  assign sn          = {cur_i.origin, cur_i.counter};
  assign counter_inc = cur_i.counter + 15'd1;
  assign limit_cur   = cur_i.peer_buf - shsa_pkg::HSK_LEN;
  assign fits_len    = item_i.length <= limit_cur;
  assign fits_hsk    = shsa_pkg::HSK_LEN <= limit_cur;
  assign take_peer   = item_i.length >= shsa_pkg::HSK_LEN;
  assign peer_buf_rx = take_peer ? item_i.peer_bufsize : cur_i.peer_buf;
  assign limit_rx    = peer_buf_rx - shsa_pkg::HSK_LEN;
  assign fits_hsk_rx = shsa_pkg::HSK_LEN <= limit_rx;
  assign match       = (cur_i.phase == shsa_pkg::PH_WAIT) && (cur_i.pending == item_i.session);
  assign peer_ck_in  = (item_i.peer_cksum_byte == shsa_pkg::CKSUM_CRC32 && !HasCrc32) ?
                       shsa_pkg::CKSUM_XOR : item_i.peer_cksum_byte;

  always_comb begin
    nxt_o = cur_i;
    res_o = '0;
    case (item_i.kind)
      shsa_pkg::KIND_HSK_START: begin
        if (cur_i.phase != shsa_pkg::PH_WAIT) begin
          nxt_o.counter = counter_inc;
          if (fits_hsk) begin
            nxt_o.phase            = shsa_pkg::PH_WAIT;
            nxt_o.pending          = sn;
            res_o.ok               = 1'b1;
            res_o.send             = 1'b1;
            res_o.send_kind        = shsa_pkg::SK_HSK_START;
            res_o.send_session     = sn;
            res_o.send_length      = shsa_pkg::HSK_LEN;
          end else begin
            nxt_o.phase = shsa_pkg::PH_IDLE;
          end
        end
      end
      shsa_pkg::KIND_SEND_NEW: begin
        nxt_o.counter = counter_inc;
        if (fits_len) begin
          res_o.ok           = 1'b1;
          res_o.send         = 1'b1;
          res_o.send_kind    = shsa_pkg::SK_USER;
          res_o.send_type    = item_i.msg_type;
          res_o.send_session = sn;
          res_o.send_length  = item_i.length;
        end
      end
      shsa_pkg::KIND_SEND_REPLY: begin
        if (fits_len) begin
          res_o.ok           = 1'b1;
          res_o.send         = 1'b1;
          res_o.send_kind    = shsa_pkg::SK_USER;
          res_o.send_type    = item_i.msg_type;
          res_o.send_session = item_i.session;
          res_o.send_length  = item_i.length;
        end
      end
      shsa_pkg::KIND_RX_START: begin
        res_o.ok = 1'b1;
        if (cur_i.phase == shsa_pkg::PH_WAIT) begin
          nxt_o.phase = shsa_pkg::PH_CONFLICT;
          if (fits_hsk) begin
            res_o.send         = 1'b1;
            res_o.send_kind    = shsa_pkg::SK_HSK_CONFLICT;
            res_o.send_session = item_i.session;
            res_o.send_length  = shsa_pkg::HSK_LEN;
          end
        end else begin
          nxt_o.origin = ~item_i.session[15];
          nxt_o.phase  = shsa_pkg::PH_DONE;
          if (take_peer) begin
            nxt_o.peer_buf   = item_i.peer_bufsize;
            nxt_o.peer_cksum = peer_ck_in;
          end
          if (fits_hsk_rx) begin
            res_o.send         = 1'b1;
            res_o.send_kind    = shsa_pkg::SK_HSK_ACCEPT;
            res_o.send_session = item_i.session;
            res_o.send_length  = shsa_pkg::HSK_LEN;
          end
        end
      end
      shsa_pkg::KIND_RX_ACCEPT: begin
        if (match) begin
          res_o.ok    = 1'b1;
          nxt_o.phase = shsa_pkg::PH_DONE;
          if (take_peer) begin
            nxt_o.peer_buf   = item_i.peer_bufsize;
            nxt_o.peer_cksum = peer_ck_in;
          end
        end
      end
      shsa_pkg::KIND_RX_CONFLICT: begin
        if (match) begin
          res_o.ok            = 1'b1;
          res_o.reset_framing = 1'b1;
          nxt_o.phase         = shsa_pkg::PH_CONFLICT;
        end
      end
      shsa_pkg::KIND_RX_OTHER: begin
        res_o.ok           = 1'b1;
        res_o.pass_to_user = 1'b1;
      end
      default: begin
      end
    endcase
    res_o.send_cksum = res_o.send ? nxt_o.peer_cksum : 8'd0;
    res_o.hsk_status = nxt_o.phase;
  end

endmodule

[sv/session_handshake_arbiter.sv]
// ----------------------------------------------------------------------------
// session_handshake_arbiter
// session and handshake decisions for a serial message endpoint
// ----------------------------------------------------------------------------
// usage
//   input channel: one event item (kind, msg_type, session, length and the
//   peer handshake bytes) is taken when in_valid_i is high and in_stall_o low
//   output channel: one result item per event, taken when out_valid_o is high
//   and out_stall_i low; all result fields are zero when send_o is low,
//   except ok_o, the flags and hsk_status_o
//   config channel: cfg_ready_o is always high; index 2 reloads the session
//   counter and index 3 the origin bit; indexes 0 and 1 hold payload values
//   that the framing side builds, so they change nothing here
//   registers: an accepted item waits in the input register, and its result is
//   loaded into the result register once the output is free; throughput: one item
//   per cycle while out_stall_i stays low, set by the single decision stage between
//   the input register and the result register; stall: while the result register
//   is held the input register holds its item and in_stall_o rises once it is full
//   reset: session counter and origin bit 0, handshake not started, peer
//   buffer size 65535, peer checksum crc32 (xor without crc support)
// ----------------------------------------------------------------------------
`include "session_handshake_arbiter_defines.svh"

module session_handshake_arbiter #(
  parameter bit HasCrc32 = 1'b1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  msg_type_i,
  input  logic [15:0] session_i,
  input  logic [15:0] length_i,
  input  logic [7:0]  peer_cksum_byte_i,
  input  logic [15:0] peer_bufsize_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        ok_o,
  output logic        send_o,
  output logic [1:0]  send_kind_o,
  output logic [7:0]  send_type_o,
  output logic [15:0] send_session_o,
  output logic [7:0]  send_cksum_o,
  output logic [15:0] send_length_o,
  output logic        pass_to_user_o,
  output logic        reset_framing_o,
  output logic [1:0]  hsk_status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam logic [7:0] PeerCksumRst = HasCrc32 ? shsa_pkg::CKSUM_CRC32 : shsa_pkg::CKSUM_XOR;

  shsa_pkg::item_t   item_q;
  shsa_pkg::state_t  state_q, state_d, state_nxt;
  shsa_pkg::result_t res_q, res_d;
  logic              in_valid_q, out_valid_q;
  logic              advance, in_accept, cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;
  assign in_accept   = in_valid_i && !in_stall_o;

  shsa_decide #(
    .HasCrc32 (HasCrc32)
  ) u_decide (
    .item_i (item_q),
    .cur_i  (state_q),
    .nxt_o  (state_nxt),
    .res_o  (res_d)
  );

  always_comb begin
    state_d = advance ? state_nxt : state_q;
    if (cfg_we) begin
      case (cfg_index_i)
        shsa_pkg::CFG_SEED:   state_d.counter = cfg_data_i[14:0];
        shsa_pkg::CFG_ORIGIN: state_d.origin  = cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q          <= 1'b0;
      out_valid_q         <= 1'b0;
      state_q.counter     <= '0;
      state_q.origin      <= 1'b0;
      state_q.pending     <= '0;
      state_q.phase       <= shsa_pkg::PH_IDLE;
      state_q.peer_buf    <= shsa_pkg::PEER_BUF_RST;
      state_q.peer_cksum  <= PeerCksumRst;
    end else begin
      state_q <= state_d;
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.kind            <= kind_i;
      item_q.msg_type        <= msg_type_i;
      item_q.session         <= session_i;
      item_q.length          <= length_i;
      item_q.peer_cksum_byte <= peer_cksum_byte_i;
      item_q.peer_bufsize    <= peer_bufsize_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign ok_o            = res_q.ok;
  assign send_o          = res_q.send;
  assign send_kind_o     = res_q.send_kind;
  assign send_type_o     = res_q.send_type;
  assign send_session_o  = res_q.send_session;
  assign send_cksum_o    = res_q.send_cksum;
  assign send_length_o   = res_q.send_length;
  assign pass_to_user_o  = res_q.pass_to_user;
  assign reset_framing_o = res_q.reset_framing;
  assign hsk_status_o    = res_q.hsk_status;

  `SHSA_ASSERT_IMP(a_send_ok, out_valid_o && send_o, ok_o, "send without ok")
  `SHSA_ASSERT_IMP(a_rfrm_conflict, out_valid_o && reset_framing_o,
                   hsk_status_o == shsa_pkg::PH_CONFLICT, "framing reset outside conflict")
  `SHSA_ASSERT_IMP(a_pass_nosend, out_valid_o && pass_to_user_o, !send_o,
                   "user pass with send")
  `SHSA_ASSERT_NXT(a_item_kept, in_valid_q && !advance, in_valid_q, "held item dropped")
  `SHSA_ASSERT_NXT(a_counter_step,
                   advance && item_q.kind == shsa_pkg::KIND_SEND_NEW && !cfg_we,
                   state_q.counter == $past(state_q.counter) + 15'd1,
                   "session counter not advanced")

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the session handshake arbiter: a directed table
// walks the handshake phases, length limits and ignored datagrams, then
// random event streams run under several register settings; every result
// item is checked field by field against a fixed table result or an in-bench
// session model, with random gaps and stalls and one long output hold
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam bit HAS_CRC32 = 1'b1;
  localparam logic [2:0] KIND_UNUSED = 3'd7;
  localparam int N_PHASES = 6;
  localparam int EVENTS_PER_PHASE = 138;
  localparam int LONG_HOLD = 40;

  typedef struct packed {
    shsa_pkg::item_t   ev;
    logic              fixed;
    shsa_pkg::result_t res;
  } row_t;

  localparam int N_ROWS = 23;
  localparam row_t ROWS [N_ROWS] = '{
    '{{shsa_pkg::KIND_SEND_NEW,    8'h00, 16'h0000, 16'hFFFF, 8'h00, 16'h0000}, 1'b1, '0},
    '{{shsa_pkg::KIND_SEND_NEW,    8'hFF, 16'h0000, 16'hFFFC, 8'h00, 16'h0000}, 1'b0, '0},
    '{{shsa_pkg::KIND_SEND_REPLY,  8'h5A, 16'hFFFF, 16'h0000, 8'h00, 16'h0000}, 1'b0, '0},
    '{{shsa_pkg::KIND_RX_ACCEPT,   8'h00, 16'h0000, 16'h0003, 8'hFF, 16'hFFFF}, 1'b1, '0},
    '{{shsa_pkg::KIND_RX_CONFLICT, 8'h00, 16'h0000, 16'h0000, 8'h00, 16'h0000}, 1'b1, '0},
    '{{shsa_pkg::KIND_RX_OTHER,    8'hA5, 16'h1234, 16'h0040, 8'h00, 16'h0000}, 1'b1,
      {1'b1, 1'b0, 2'd0, 8'd0, 16'd0, 8'd0, 16'd0, 1'b1, 1'b0, shsa_pkg::PH_IDLE}},
    '{{KIND_UNUSED,                8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF}, 1'b1, '0},
    '{{shsa_pkg::KIND_HSK_START,   8'h00, 16'h0000, 16'h0000, 8'h00, 16'h0000}, 1'b0, '0},
    '{{shsa_pkg::KIND_HSK_START,   8'h00, 16'h0000, 16'h0000, 8'h00, 16'h0000}, 1'b0, '0},
    '{{shsa_pkg::KIND_RX_ACCEPT,   8'h00, 16'h0003, 16'h0003, 8'h01, 16'h0002}, 1'b0, '0},
    '{{shsa_pkg::KIND_RX_ACCEPT,   8'h00, 16'h0002, 16'h0003, 8'h01, 16'h0002}, 1'b0, '0},
    '{{shsa_pkg::KIND_SEND_NEW,    8'h81, 16'h0000, 16'hFFFF, 8'h00, 16'h0000}, 1'b0, '0},
    '{{shsa_pkg::KIND_RX_START,    8'h00, 16'h8000, 16'h0003, 8'h00, 16'h0005}, 1'b0, '0},
    '{{shsa_pkg::KIND_HSK_START,   8'h00, 16'h0000, 16'h0000, 8'h00, 16'h0000}, 1'b0, '0},
    '{{shsa_pkg::KIND_RX_START,    8'h00, 16'h0000, 16'h0002, 8'h55, 16'hAAAA}, 1'b0, '0},
    '{{shsa_pkg::KIND_RX_START,    8'h00, 16'h7FFF, 16'hFFFF, 8'hFF, 16'hFFFF}, 1'b0, '0},
    '{{shsa_pkg::KIND_HSK_START,   8'h00, 16'h0000, 16'h0000, 8'h00, 16'h0000}, 1'b0, '0},
    '{{shsa_pkg::KIND_RX_START,    8'h00, 16'h1234, 16'h0003, 8'h01, 16'h0100}, 1'b0, '0},
    '{{shsa_pkg::KIND_HSK_START,   8'h00, 16'h0000, 16'h0000, 8'h00, 16'h0000}, 1'b0, '0},
    '{{shsa_pkg::KIND_RX_CONFLICT, 8'h00, 16'h8006, 16'h0000, 8'h00, 16'h0000}, 1'b0, '0},
    '{{shsa_pkg::KIND_HSK_START,   8'h00, 16'h0000, 16'h0000, 8'h00, 16'h0000}, 1'b0, '0},
    '{{shsa_pkg::KIND_RX_ACCEPT,   8'h00, 16'h8007, 16'h0002, 8'h20, 16'h0004}, 1'b0, '0},
    '{{shsa_pkg::KIND_RX_START,    8'h00, 16'h8000, 16'h0003, 8'h20, 16'h0004}, 1'b0, '0}
  };

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  shsa_pkg::item_t   drv;
  logic              out_valid;
  logic              out_stall;
  logic              ok;
  logic              send;
  logic [1:0]        send_kind;
  logic [7:0]        send_type;
  logic [15:0]       send_session;
  logic [7:0]        send_cksum;
  logic [15:0]       send_length;
  logic              pass_to_user;
  logic              reset_framing;
  logic [1:0]        hsk_status;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [1:0]        cfg_index;
  logic [15:0]       cfg_data;

  shsa_pkg::state_t  sess;
  shsa_pkg::result_t decision_q [$];
  logic              row_fixed;
  shsa_pkg::result_t row_result;
  bit                quiet;
  int                events_sent;
  int                mismatches;

  session_handshake_arbiter #(
    .HasCrc32(HAS_CRC32)
  ) uut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .kind_i           (drv.kind),
    .msg_type_i       (drv.msg_type),
    .session_i        (drv.session),
    .length_i         (drv.length),
    .peer_cksum_byte_i(drv.peer_cksum_byte),
    .peer_bufsize_i   (drv.peer_bufsize),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .ok_o             (ok),
    .send_o           (send),
    .send_kind_o      (send_kind),
    .send_type_o      (send_type),
    .send_session_o   (send_session),
    .send_cksum_o     (send_cksum),
    .send_length_o    (send_length),
    .pass_to_user_o   (pass_to_user),
    .reset_framing_o  (reset_framing),
    .hsk_status_o     (hsk_status),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic logic fits(logic [15:0] len);
    logic [15:0] room;
    room = sess.peer_buf - shsa_pkg::HSK_LEN;
    return len <= room;
  endfunction

  function automatic logic [15:0] claim_session();
    logic [15:0] sid;
    sid = {sess.origin, sess.counter};
    sess.counter = sess.counter + 15'd1;
    return sid;
  endfunction

  function automatic void learn_peer(logic [7:0] code, logic [15:0] size);
    sess.peer_cksum = code;
    sess.peer_buf = size;
    if (!HAS_CRC32 && code == shsa_pkg::CKSUM_CRC32) begin
      sess.peer_cksum = shsa_pkg::CKSUM_XOR;
    end
  endfunction

  function automatic shsa_pkg::result_t arbitrate(shsa_pkg::item_t ev);
    shsa_pkg::result_t r;
    logic [15:0] sid;
    r = '0;
    case (ev.kind)
      shsa_pkg::KIND_HSK_START: begin
        if (sess.phase != shsa_pkg::PH_WAIT) begin
          sid = claim_session();
          if (fits(shsa_pkg::HSK_LEN)) begin
            sess.phase = shsa_pkg::PH_WAIT;
            sess.pending = sid;
            r.ok = 1'b1;
            r.send = 1'b1;
            r.send_kind = shsa_pkg::SK_HSK_START;
            r.send_session = sid;
            r.send_length = shsa_pkg::HSK_LEN;
          end else begin
            sess.phase = shsa_pkg::PH_IDLE;
          end
        end
      end
      shsa_pkg::KIND_SEND_NEW: begin
        sid = claim_session();
        if (fits(ev.length)) begin
          r.ok = 1'b1;
          r.send = 1'b1;
          r.send_kind = shsa_pkg::SK_USER;
          r.send_type = ev.msg_type;
          r.send_session = sid;
          r.send_length = ev.length;
        end
      end
      shsa_pkg::KIND_SEND_REPLY: begin
        if (fits(ev.length)) begin
          r.ok = 1'b1;
          r.send = 1'b1;
          r.send_kind = shsa_pkg::SK_USER;
          r.send_type = ev.msg_type;
          r.send_session = ev.session;
          r.send_length = ev.length;
        end
      end
      shsa_pkg::KIND_RX_START: begin
        r.ok = 1'b1;
        if (sess.phase == shsa_pkg::PH_WAIT) begin
          if (fits(shsa_pkg::HSK_LEN)) begin
            r.send = 1'b1;
            r.send_kind = shsa_pkg::SK_HSK_CONFLICT;
            r.send_session = ev.session;
            r.send_length = shsa_pkg::HSK_LEN;
          end
          sess.phase = shsa_pkg::PH_CONFLICT;
        end else begin
          sess.origin = ~ev.session[15];
          if (ev.length >= shsa_pkg::HSK_LEN) begin
            learn_peer(ev.peer_cksum_byte, ev.peer_bufsize);
          end
          sess.phase = shsa_pkg::PH_DONE;
          if (fits(shsa_pkg::HSK_LEN)) begin
            r.send = 1'b1;
            r.send_kind = shsa_pkg::SK_HSK_ACCEPT;
            r.send_session = ev.session;
            r.send_length = shsa_pkg::HSK_LEN;
          end
        end
      end
      shsa_pkg::KIND_RX_ACCEPT: begin
        if (sess.phase == shsa_pkg::PH_WAIT && sess.pending == ev.session) begin
          r.ok = 1'b1;
          if (ev.length >= shsa_pkg::HSK_LEN) begin
            learn_peer(ev.peer_cksum_byte, ev.peer_bufsize);
          end
          sess.phase = shsa_pkg::PH_DONE;
        end
      end
      shsa_pkg::KIND_RX_CONFLICT: begin
        if (sess.phase == shsa_pkg::PH_WAIT && sess.pending == ev.session) begin
          r.ok = 1'b1;
          r.reset_framing = 1'b1;
          sess.phase = shsa_pkg::PH_CONFLICT;
        end
      end
      shsa_pkg::KIND_RX_OTHER: begin
        r.ok = 1'b1;
        r.pass_to_user = 1'b1;
      end
      default: begin
      end
    endcase
    if (r.send) begin
      r.send_cksum = sess.peer_cksum;
    end
    r.hsk_status = sess.phase;
    return r;
  endfunction

  // payload registers only feed the framing side, nothing to track here
  function automatic void load_register(logic [1:0] idx, logic [15:0] data);
    case (idx)
      shsa_pkg::CFG_SEED:   sess.counter = data[14:0];
      shsa_pkg::CFG_ORIGIN: sess.origin = data[0];
      default: begin
      end
    endcase
  endfunction

  function automatic shsa_pkg::item_t make_event();
    shsa_pkg::item_t ev;
    int pick;
    logic [15:0] room;
    room = sess.peer_buf - shsa_pkg::HSK_LEN;
    pick = $urandom_range(0, 99);
    ev.msg_type = 8'($urandom);
    ev.session = 16'($urandom);
    if (sess.phase == shsa_pkg::PH_WAIT) begin
      if (pick < 40) ev.kind = shsa_pkg::KIND_RX_ACCEPT;
      else if (pick < 60) ev.kind = shsa_pkg::KIND_RX_CONFLICT;
      else if (pick < 70) ev.kind = shsa_pkg::KIND_RX_START;
      else if (pick < 80) ev.kind = shsa_pkg::KIND_HSK_START;
      else if (pick < 88) ev.kind = shsa_pkg::KIND_SEND_NEW;
      else if (pick < 94) ev.kind = shsa_pkg::KIND_SEND_REPLY;
      else ev.kind = shsa_pkg::KIND_RX_OTHER;
      if ((ev.kind == shsa_pkg::KIND_RX_ACCEPT || ev.kind == shsa_pkg::KIND_RX_CONFLICT) &&
          $urandom_range(0, 4) != 0) begin
        ev.session = sess.pending;
      end
    end else begin
      if (pick < 30) ev.kind = shsa_pkg::KIND_HSK_START;
      else if (pick < 45) ev.kind = shsa_pkg::KIND_SEND_NEW;
      else if (pick < 57) ev.kind = shsa_pkg::KIND_SEND_REPLY;
      else if (pick < 70) ev.kind = shsa_pkg::KIND_RX_START;
      else if (pick < 78) ev.kind = shsa_pkg::KIND_RX_ACCEPT;
      else if (pick < 85) ev.kind = shsa_pkg::KIND_RX_CONFLICT;
      else ev.kind = shsa_pkg::KIND_RX_OTHER;
    end
    case ($urandom_range(0, 3))
      0: ev.length = 16'($urandom_range(0, 5));
      1: ev.length = 16'(room + 16'($urandom_range(0, 2)) - 16'd1);
      2: ev.length = 16'($urandom);
      default: ev.length = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endcase
    case ($urandom_range(0, 3))
      0: ev.peer_bufsize = 16'($urandom_range(0, 8));
      1: ev.peer_bufsize = 16'($urandom_range(64, 1024));
      2: ev.peer_bufsize = 16'hFFFF;
      default: ev.peer_bufsize = 16'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: ev.peer_cksum_byte = shsa_pkg::CKSUM_CRC32;
      1: ev.peer_cksum_byte = shsa_pkg::CKSUM_XOR;
      2: ev.peer_cksum_byte = 8'h00;
      default: ev.peer_cksum_byte = 8'($urandom);
    endcase
    return ev;
  endfunction

  // called at a falling edge, returns at the edge that takes the item
  task automatic send_event(input shsa_pkg::item_t ev);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    drv <= ev;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    events_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_registers(input logic [15:0] own_size, input logic [15:0] own_code,
                               input logic [15:0] seed, input logic [15:0] origin_val);
    while (decision_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    write_reg(shsa_pkg::CFG_OWN_BUF, own_size);
    write_reg(shsa_pkg::CFG_OWN_CKSUM, own_code);
    write_reg(shsa_pkg::CFG_SEED, seed);
    write_reg(shsa_pkg::CFG_ORIGIN, origin_val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    shsa_pkg::result_t want;
    shsa_pkg::result_t got;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        load_register(cfg_index, cfg_data);
      end
      if (in_valid && !in_stall) begin
        want = arbitrate(drv);
        decision_q.push_back(row_fixed ? row_result : want);
      end
      if (out_valid && !out_stall) begin
        got = {ok, send, send_kind, send_type, send_session, send_cksum, send_length,
               pass_to_user, reset_framing, hsk_status};
        if (decision_q.size() == 0) begin
          $error("result item with no decision pending");
          mismatches++;
        end else begin
          want = decision_q.pop_front();
          check_field("ok", 16'(want.ok), 16'(got.ok));
          check_field("send", 16'(want.send), 16'(got.send));
          check_field("send_kind", 16'(want.send_kind), 16'(got.send_kind));
          check_field("send_type", 16'(want.send_type), 16'(got.send_type));
          check_field("send_session", want.send_session, got.send_session);
          check_field("send_cksum", 16'(want.send_cksum), 16'(got.send_cksum));
          check_field("send_length", want.send_length, got.send_length);
          check_field("pass_to_user", 16'(want.pass_to_user), 16'(got.pass_to_user));
          check_field("reset_framing", 16'(want.reset_framing), 16'(got.reset_framing));
          check_field("hsk_status", 16'(want.hsk_status), 16'(got.hsk_status));
        end
      end
    end
  end

  // random output stalls, plus one long hold so the input side backs up
  initial begin : receiver
    bit held_long;
    held_long = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_long && events_sent >= 300) begin
        held_long = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    rst_n = 1'b0;
    in_valid = 1'b0;
    drv = '0;
    cfg_valid = 1'b0;
    cfg_index = shsa_pkg::CFG_OWN_BUF;
    cfg_data = '0;
    quiet = 1'b0;
    row_fixed = 1'b0;
    row_result = '0;
    events_sent = 0;
    mismatches = 0;
    sess = '{counter: '0, origin: 1'b0, pending: '0, phase: shsa_pkg::PH_IDLE,
             peer_buf: shsa_pkg::PEER_BUF_RST,
             peer_cksum: HAS_CRC32 ? shsa_pkg::CKSUM_CRC32 : shsa_pkg::CKSUM_XOR};
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < N_ROWS; i++) begin
      @(negedge clk);
      row_fixed = ROWS[i].fixed;
      row_result = ROWS[i].res;
      send_event(ROWS[i].ev);
    end
    @(negedge clk);
    in_valid <= 1'b0;
    row_fixed = 1'b0;

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: set_registers(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        1: set_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        default: set_registers(16'($urandom), 16'($urandom),
                               $urandom_range(0, 1) ? 16'h7FFE : 16'($urandom),
                               16'($urandom));
      endcase
      quiet = (p == N_PHASES - 1);
      for (int n = 0; n < EVENTS_PER_PHASE; n++) begin
        @(negedge clk);
        send_event(make_event());
      end
      @(negedge clk);
      in_valid <= 1'b0;
    end

    while (decision_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (mismatches == 0 && decision_q.size() == 0) begin
      $display("session_handshake_arbiter verification clean");
    end else begin
      $display("session_handshake_arbiter verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("session_handshake_arbiter verification failed");
    $finish;
  end

endmodule
